// File: hdl/fcce_pkg.sv
// ============================================================================
// FAT32 cluster chain engine package
// Shared payload types, operation and status codes, and table constants.
// ============================================================================
`default_nettype none

package fcce_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 65536;
   localparam int unsigned MAX_CHAIN_DEF     = 64;
   localparam int unsigned QUEUE_DEPTH       = 4;

   localparam logic [31:0] EOC_MARK   = 32'h0FFF_FFF8;
   localparam logic [31:0] FIRST_DATA = 32'd2;
   localparam logic [16:0] LCI_RESET  = 17'd65536;

   // operation codes carried in func
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_WALK  = 2'd1;
   localparam logic [1:0] OP_NEXT  = 2'd2;
   localparam logic [1:0] OP_COUNT = 2'd3;

   // result status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_END     = 2'd1;
   localparam logic [1:0] STS_INVALID = 2'd2;
   localparam logic [1:0] STS_TRUNC   = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] cluster;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
      logic [1:0]  status;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] cluster;
      logic [31:0] entry_value;
      logic        idx_ok;
   } cmd_type;

   function automatic logic cluster_ok(input logic [31:0] c, input logic [31:0] entries);
      return (c >= FIRST_DATA) && (c < entries);
   endfunction

endpackage

`default_nettype wire

// File: hdl/fcce_front.sv
// ============================================================================
// FAT32 cluster chain engine front end
// Accepts request transactions, classifies them and queues them for the back.
// ============================================================================
`default_nettype none

module fcce_front #(
   parameter int unsigned TABLE_ENTRIES = fcce_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fcce_pkg::req_type req_data,
   output logic                  cmd_valid,
   output fcce_pkg::cmd_type     cmd_data,
   input  wire logic             cmd_pop
);

   localparam int unsigned QD  = fcce_pkg::QUEUE_DEPTH;
   localparam int unsigned QAW = $clog2(QD);
   localparam int unsigned QCW = $clog2(QD + 1);

   fcce_pkg::cmd_type q_ff [QD];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   fcce_pkg::cmd_type cls;
   logic push;
   logic in_range;

   assign req_stall = (cnt_ff == QCW'(QD));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   assign in_range = ({16'd0, req_data.cluster} < 32'(TABLE_ENTRIES));

   always_comb begin
      cls.op          = req_data.func;
      cls.cluster     = req_data.cluster;
      cls.entry_value = req_data.entry_value;
      unique case (req_data.func) inside
         fcce_pkg::OP_LOAD: begin
            cls.idx_ok = in_range;
         end
         fcce_pkg::OP_WALK, fcce_pkg::OP_NEXT: begin
            cls.idx_ok = fcce_pkg::cluster_ok({16'd0, req_data.cluster}, 32'(TABLE_ENTRIES));
         end
         default: begin
            cls.idx_ok = 1'b1;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCW'(push) - QCW'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// File: hdl/fcce_back.sv
// ============================================================================
// FAT32 cluster chain engine back end
// Holds the allocation table and sequences loads, walks, lookups and counts.
// ============================================================================
`default_nettype none

module fcce_back #(
   parameter int unsigned TABLE_ENTRIES = fcce_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_CHAIN     = fcce_pkg::MAX_CHAIN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire fcce_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   input  wire logic              csr_wr_en,
   input  wire logic [16:0]       csr_wr_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fcce_pkg::rsp_type      rsp_data
);

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned KW = $clog2(MAX_CHAIN);
   localparam logic [31:0] ENTRIES = 32'(TABLE_ENTRIES);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHK     = 3'd1;
   localparam logic [2:0] S_EVAL    = 3'd2;
   localparam logic [2:0] S_CNT     = 3'd3;
   localparam logic [2:0] S_CNT_OUT = 3'd4;

   logic [31:0] fat_table_ff [TABLE_ENTRIES];
   logic [31:0] rd_data_ff;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   cur_ff, cur_in;
   logic [KW-1:0] step_ff, step_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] free_ff, free_in;
   logic          pend_ff, pend_in;
   logic [16:0]   lci_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   fcce_pkg::rsp_type rsp_data_ff;

   logic          out_free;
   logic          emit;
   fcce_pkg::rsp_type emit_data;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   bound;
   logic          more;
   logic          eoc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign bound     = ({15'd0, lci_ff} > ENTRIES) ? ENTRIES : {15'd0, lci_ff};
   assign more      = (32'(scan_ff) < bound);
   assign eoc       = (rd_data_ff >= fcce_pkg::EOC_MARK);
   assign mem_waddr = AW'(cmd_data.cluster);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cur_in    = cur_ff;
      step_in   = step_ff;
      scan_in   = scan_ff;
      free_in   = free_ff;
      pend_in   = pend_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = cur_ff[AW-1:0];
      emit      = 1'b0;
      emit_data = '{value: cur_ff, last: 1'b1, status: fcce_pkg::STS_OK};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               op_in   = cmd_data.op;
               cur_in  = {16'd0, cmd_data.cluster};
               step_in = '0;
               unique case (cmd_data.op) inside
                  fcce_pkg::OP_LOAD: begin
                     mem_we = cmd_data.idx_ok;
                  end
                  fcce_pkg::OP_WALK, fcce_pkg::OP_NEXT: begin
                     state_in = S_CHK;
                  end
                  default: begin
                     scan_in  = CW'(fcce_pkg::FIRST_DATA);
                     free_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_CNT;
                  end
               endcase
            end
         end
         S_CHK: begin
            if (!fcce_pkg::cluster_ok(cur_ff, ENTRIES)) begin
               if (out_free) begin
                  emit = 1'b1;
                  emit_data.value  = (op_ff == fcce_pkg::OP_WALK) ? cur_ff : 32'd0;
                  emit_data.status = fcce_pkg::STS_INVALID;
                  state_in = S_IDLE;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            // read data holds until the result slot frees up
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (op_ff == fcce_pkg::OP_NEXT) begin
                  emit_data.value  = eoc ? 32'd0 : rd_data_ff;
                  emit_data.status = eoc ? fcce_pkg::STS_END : fcce_pkg::STS_OK;
               end else if (!eoc) begin
                  if (step_ff == KW'(MAX_CHAIN - 1)) begin
                     emit_data.status = fcce_pkg::STS_TRUNC;
                  end else begin
                     emit_data.last = 1'b0;
                     cur_in   = rd_data_ff;
                     step_in  = step_ff + KW'(1);
                     state_in = S_CHK;
                  end
               end
            end
         end
         S_CNT: begin
            mem_raddr = scan_ff[AW-1:0];
            if (pend_ff && rd_data_ff == 32'd0) begin
               free_in = free_ff + CW'(1);
            end
            mem_re  = more;
            pend_in = more;
            if (more) begin
               scan_in = scan_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = S_CNT_OUT;
            end
         end
         S_CNT_OUT: begin
            if (out_free) begin
               emit = 1'b1;
               emit_data.value = 32'(free_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lci_ff       <= fcce_pkg::LCI_RESET;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            lci_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cur_ff  <= cur_in;
      step_ff <= step_in;
      scan_ff <= scan_in;
      free_ff <= free_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fat_table_ff[mem_waddr] <= cmd_data.entry_value;
      end
      if (mem_re) begin
         rd_data_ff <= fat_table_ff[mem_raddr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/fat32_cluster_chain_engine_core.sv
// ============================================================================
// FAT32 cluster chain engine
// Allocation table store with chain walk, next lookup and free count.
// ============================================================================
// Request transactions (req_valid / req_stall / req_data) carry func, cluster
// and entry_value; result transactions (rsp_valid / rsp_stall / rsp_data)
// carry value, last and status. csr_wr_en writes last_cluster_index.
// Requests enter a four-deep command queue, so the front keeps taking them
// while the back end works or while a result waits for the receiver.
// A load gives no result.
// A next lookup gives one result: the back end checks the cluster, reads the table entry and registers the result.
// A walk checks and reads each link in turn on the single table read port, so a
// chain gives n results, n at most MAX_CHAIN.
// A free count reads one entry per cycle from cluster 2 up to bound - 1,
// with bound the smaller of last_cluster_index and TABLE_ENTRIES.
// When rsp_stall is high the pending result holds and the back end waits
// before giving another result; the queue fills and then req_stall rises.
// Reset empties the queue, drops any pending result and sets
// last_cluster_index to 65536. Table contents are undefined until loaded.
// ============================================================================
`default_nettype none

module fat32_cluster_chain_engine_core #(
   parameter int unsigned TABLE_ENTRIES = fcce_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_CHAIN     = fcce_pkg::MAX_CHAIN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire fcce_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fcce_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [16:0]       csr_wr_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   fcce_pkg::cmd_type cmd_data;

   fcce_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   fcce_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CHAIN     (MAX_CHAIN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/fcce_checker.sv
// ============================================================================
// FAT32 cluster chain engine checker
// Port level assertions on the result channel, bound to the top level.
// ============================================================================
`default_nettype none

module fcce_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire fcce_pkg::rsp_type rsp_data
);

   // a stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // only a plain ok result of a walk may continue the chain
   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != fcce_pkg::STS_OK |-> rsp_data.last)
      else $error("error status without last");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == fcce_pkg::STS_END |-> rsp_data.value == 32'd0)
      else $error("end of chain result with non-zero value");

endmodule

bind fat32_cluster_chain_engine_core fcce_checker u_fcce_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
